@@ rtl/core/psd_pkg.sv @@
// Package: widths, region codes and register indexes for the segment distance block
package psd_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned ValW    = 38;
  localparam int unsigned RegionW = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  // root cells: one result bit per cell
  localparam int unsigned RootBits = ValW / 2;
  localparam int unsigned RemW     = RootBits + 2;

  typedef enum logic [RegionW-1:0] {
    REGION_PERP   = 2'd0,
    REGION_BEFORE = 2'd1,
    REGION_PAST   = 2'd2
  } region_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_START_Z = 3'd2,
    CFG_DIR_X   = 3'd3,
    CFG_DIR_Y   = 3'd4,
    CFG_DIR_Z   = 3'd5,
    CFG_LENGTH  = 3'd6,
    CFG_ROOT    = 3'd7
  } cfg_idx_e;

  // one step of the digit-by-digit square root as it moves down the row
  typedef struct packed {
    logic               vld;
    logic               root_mode;
    region_e            region;
    logic [ValW-1:0]    rad;   // radicand, shifted left two bits per cell
    logic [RemW-1:0]    rem;
    logic [RootBits-1:0] root;
  } sqrt_tok_t;

endpackage

@@ rtl/core/psd_if.sv @@
// Interfaces: valid/ready request channels for points and results
interface psd_point_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface psd_result_if;
  logic        valid;
  logic        ready;
  logic [37:0] distance_value;
  logic [1:0]  region;
  modport source (output valid, distance_value, region, input ready);
  modport sink   (input valid, distance_value, region, output ready);
endinterface

@@ rtl/core/psd_sqrt_cell.sv @@
// One cell of the square root row: retires one result bit per cycle while enabled
module psd_sqrt_cell import psd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  sqrt_tok_t tok_i,
  output sqrt_tok_t tok_o
);
  sqrt_tok_t tok_d, dat_q;
  logic      vld_q;
  logic [RemW-1:0] trial, rem_sh, cand;

  // bring down two radicand bits, try subtracting 4*root+1
  always_comb begin
    rem_sh = {tok_i.rem[RemW-3:0], tok_i.rad[ValW-1 -: 2]};
    cand   = {tok_i.root, 2'b01};
    trial  = rem_sh - cand;
    tok_d  = tok_i;
    tok_d.rad = {tok_i.rad[ValW-3:0], 2'b00};
    if (rem_sh >= cand) begin
      tok_d.rem  = trial;
      tok_d.root = {tok_i.root[RootBits-2:0], 1'b1};
    end else begin
      tok_d.rem  = rem_sh;
      tok_d.root = {tok_i.root[RootBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= tok_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= tok_d;
    end
  end

  // valid comes from the reset register, the rest from the data register
  always_comb begin
    tok_o     = dat_q;
    tok_o.vld = vld_q;
  end
endmodule

@@ rtl/core/psd_geom.sv @@
// Geometry front end: difference, projection, cross product, squared distance
module psd_geom import psd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic signed [15:0]       px_i, py_i, pz_i,
  input  logic signed [15:0]       sx_i, sy_i, sz_i,
  input  logic signed [15:0]       dx_i, dy_i, dz_i,
  input  logic [15:0]              len_i,
  input  logic                     root_i,
  output sqrt_tok_t                tok_o
);
  // stage 1: differences and operand copies
  logic               v1_q, r1_q;
  logic signed [16:0] d1x_q, d1y_q, d1z_q;
  logic signed [15:0] dvx_q, dvy_q, dvz_q;
  logic [15:0]        len1_q;
  logic signed [16:0] p1x_q, p1y_q, p1z_q;   // point copies, sign extended
  logic signed [16:0] s1x_q, s1y_q, s1z_q;

  // stage 2: products
  logic               v2_q, r2_q;
  logic signed [33:0] ta_q, tb_q, tc_q;
  logic signed [33:0] c0a_q, c0b_q, c1a_q, c1b_q, c2a_q, c2b_q;
  logic signed [16:0] d2x_q, d2y_q, d2z_q;
  logic signed [32:0] e0_q, e1_q, e2_q;      // dir * len, Q.22
  logic signed [16:0] p2x_q, p2y_q, p2z_q, s2x_q, s2y_q, s2z_q;
  logic [15:0]        len2_q;

  // stage 3: region decision, operands to square
  logic               v3_q, r3_q;
  region_e            reg3_q;
  logic [19:0]        m0_q, m1_q, m2_q;

  // stage 4: squares, summed combinationally at the output
  logic               v4_q, r4_q;
  region_e            reg4_q;
  logic [39:0]        q0_q, q1_q, q2_q;

  function automatic logic [19:0] rnd14(input logic signed [34:0] v);
    logic [34:0] m;
    m = v[34] ? 35'(-v) : 35'(v);
    return 20'((m + 35'd8192) >> 14);
  endfunction

  function automatic logic [19:0] absv(input logic signed [19:0] v);
    return v[19] ? 20'(-v) : 20'(v);
  endfunction

  logic signed [34:0] t3, c0, c1, c2;
  logic signed [34:0] lim;
  logic signed [19:0] q0, q1, q2;
  logic [19:0]        r0, r1, r2;

  always_comb begin
    t3  = 35'(ta_q) + 35'(tb_q) + 35'(tc_q);
    lim = 35'(signed'({1'b0, len2_q})) <<< 14;
    c0  = 35'(c0a_q) - 35'(c0b_q);
    c1  = 35'(c1a_q) - 35'(c1b_q);
    c2  = 35'(c2a_q) - 35'(c2b_q);
    r0  = rnd14(35'(e0_q));
    r1  = rnd14(35'(e1_q));
    r2  = rnd14(35'(e2_q));
    q0  = 20'(p2x_q) - (20'(s2x_q) + (e0_q[32] ? -20'(r0) : 20'(r0)));
    q1  = 20'(p2y_q) - (20'(s2y_q) + (e1_q[32] ? -20'(r1) : 20'(r1)));
    q2  = 20'(p2z_q) - (20'(s2z_q) + (e2_q[32] ? -20'(r2) : 20'(r2)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q <= root_i;  len1_q <= len_i;
      p1x_q <= 17'(px_i); p1y_q <= 17'(py_i); p1z_q <= 17'(pz_i);
      s1x_q <= 17'(sx_i); s1y_q <= 17'(sy_i); s1z_q <= 17'(sz_i);
      d1x_q <= 17'(px_i) - 17'(sx_i);
      d1y_q <= 17'(py_i) - 17'(sy_i);
      d1z_q <= 17'(pz_i) - 17'(sz_i);
      dvx_q <= dx_i; dvy_q <= dy_i; dvz_q <= dz_i;

      r2_q <= r1_q; len2_q <= len1_q;
      d2x_q <= d1x_q; d2y_q <= d1y_q; d2z_q <= d1z_q;
      p2x_q <= p1x_q; p2y_q <= p1y_q; p2z_q <= p1z_q;
      s2x_q <= s1x_q; s2y_q <= s1y_q; s2z_q <= s1z_q;
      ta_q  <= 34'(d1x_q * dvx_q);
      tb_q  <= 34'(d1y_q * dvy_q);
      tc_q  <= 34'(d1z_q * dvz_q);
      c0a_q <= 34'(d1y_q * dvz_q); c0b_q <= 34'(d1z_q * dvy_q);
      c1a_q <= 34'(d1z_q * dvx_q); c1b_q <= 34'(d1x_q * dvz_q);
      c2a_q <= 34'(d1x_q * dvy_q); c2b_q <= 34'(d1y_q * dvx_q);
      e0_q  <= 33'(dvx_q * signed'({1'b0, len1_q}));
      e1_q  <= 33'(dvy_q * signed'({1'b0, len1_q}));
      e2_q  <= 33'(dvz_q * signed'({1'b0, len1_q}));

      r3_q <= r2_q;
      if (!t3[34] && t3 <= lim) begin
        reg3_q <= REGION_PERP;
        m0_q <= rnd14(c0); m1_q <= rnd14(c1); m2_q <= rnd14(c2);
      end else if (t3[34]) begin
        reg3_q <= REGION_BEFORE;
        m0_q <= absv(20'(d2x_q)); m1_q <= absv(20'(d2y_q)); m2_q <= absv(20'(d2z_q));
      end else begin
        reg3_q <= REGION_PAST;
        m0_q <= absv(q0); m1_q <= absv(q1); m2_q <= absv(q2);
      end

      r4_q <= r3_q; reg4_q <= reg3_q;
      q0_q <= 40'(m0_q) * 40'(m0_q);
      q1_q <= 40'(m1_q) * 40'(m1_q);
      q2_q <= 40'(m2_q) * 40'(m2_q);
    end
  end

  logic [41:0] sum;
  always_comb begin
    sum = 42'(q0_q) + 42'(q1_q) + 42'(q2_q);
    tok_o.vld       = v4_q;
    tok_o.root_mode = r4_q;
    tok_o.region    = reg4_q;
    tok_o.rad       = (sum > 42'((64'd1 << ValW) - 1)) ? '1 : sum[ValW-1:0];
    tok_o.rem       = '0;
    tok_o.root      = '0;
  end
endmodule

@@ rtl/core/point_segment_distance.sv @@
// Top level: point to 3D line segment distance, one point per cycle
//
//  channel  dir  payload
//  pt_in    in   point_x, point_y, point_z (signed Q8.8)
//  res_out  out  distance_value (38b), region (2b)
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// One request per cycle sustained while the output is not stalled; the path is 4 geometry
// stages, 19 root cells and the output register, the same in both modes.
// The whole pipeline advances together; a stalled output holds every stage.
// Reset clears valids and loads the register defaults (direction +x).
module point_segment_distance import psd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  psd_point_if.sink           pt_in,
  psd_result_if.source        res_out
);
  logic signed [15:0] sx_q, sy_q, sz_q, dx_q, dy_q, dz_q;
  logic [15:0]        len_q;
  logic               root_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0; sy_q <= '0; sz_q <= '0;
      dx_q <= 16'sd16384; dy_q <= '0; dz_q <= '0;
      len_q <= '0; root_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_X: sx_q   <= cfg_data_i;
        CFG_START_Y: sy_q   <= cfg_data_i;
        CFG_START_Z: sz_q   <= cfg_data_i;
        CFG_DIR_X:   dx_q   <= cfg_data_i;
        CFG_DIR_Y:   dy_q   <= cfg_data_i;
        CFG_DIR_Z:   dz_q   <= cfg_data_i;
        CFG_LENGTH:  len_q  <= cfg_data_i;
        CFG_ROOT:    root_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless a finished result is stuck at the output
  logic en;
  assign en = !res_out.valid || res_out.ready;
  assign pt_in.ready = en;

  sqrt_tok_t chain [RootBits+1];

  psd_geom u_geom (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(pt_in.valid),
    .px_i(pt_in.point_x), .py_i(pt_in.point_y), .pz_i(pt_in.point_z),
    .sx_i(sx_q), .sy_i(sy_q), .sz_i(sz_q),
    .dx_i(dx_q), .dy_i(dy_q), .dz_i(dz_q),
    .len_i(len_q), .root_i(root_q),
    .tok_o(chain[0])
  );

  // row of root cells
  for (genvar g = 0; g < RootBits; g++) begin : g_cell
    psd_sqrt_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .tok_i(chain[g]), .tok_o(chain[g+1])
    );
  end

  // output register; squared value rides behind the root in a side shift line
  logic [ValW-1:0] sq_line [RootBits+1];
  assign sq_line[0] = chain[0].rad;
  for (genvar g = 0; g < RootBits; g++) begin : g_sq
    logic [ValW-1:0] sq_q;
    always_ff @(posedge clk_i) if (en) sq_q <= sq_line[g];
    assign sq_line[g+1] = sq_q;
  end

  logic            ov_q;
  logic [ValW-1:0] oval_q;
  region_e         oreg_q;
  sqrt_tok_t       last;
  assign last = chain[RootBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= last.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oreg_q <= last.region;
      oval_q <= last.root_mode ? ValW'(last.root) : sq_line[RootBits];
    end
  end

  assign res_out.valid          = ov_q;
  assign res_out.distance_value = oval_q;
  assign res_out.region         = oreg_q;
endmodule

@@ verif/point_segment_distance_tb.sv @@
// Testbench for the point to segment distance block: directed table plus random queries
`timescale 1ns / 100ps

module point_segment_distance_tb import psd_pkg::*; ();

  typedef struct packed {
    logic [ValW-1:0] value;
    region_e         region;
  } dist_t;

  // directed row: known rows carry a typed-in answer, the others go to the predictor
  typedef struct {
    logic signed [15:0] x, y, z;
    bit                 known;
    logic [ValW-1:0]    value;
    region_e            region;
  } point_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  psd_point_if  pt_in ();
  psd_result_if res_out ();

  point_segment_distance dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pt_in(pt_in.sink), .res_out(res_out.source)
  );

  always #10 clk_i = ~clk_i;

  // segment registers as the block should hold them
  logic [15:0] seg_regs [8];
  dist_t       expected_dist [$];
  int          mismatches = 0;
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;

  initial begin
    pt_in.valid   = 1'b0;
    pt_in.point_x = '0;
    pt_in.point_y = '0;
    pt_in.point_z = '0;
    res_out.ready = 1'b0;
  end

  function automatic longint sext16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  // Q.22 magnitude rounded half away from zero to Q.8
  function automatic longint round_q22(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    return (m + 8192) >>> 14;
  endfunction

  function automatic dist_t predict_distance(logic [15:0] px, logic [15:0] py,
                                             logic [15:0] pz);
    longint p[3], s[3], dv[3], d[3], c[3];
    longint t, len, e, q;
    longint unsigned sq, root, trial;
    dist_t r;
    p[0] = sext16(px); p[1] = sext16(py); p[2] = sext16(pz);
    len = longint'(seg_regs[CFG_LENGTH]);
    for (int i = 0; i < 3; i++) begin
      s[i]  = sext16(seg_regs[i]);
      dv[i] = sext16(seg_regs[3 + i]);
      d[i]  = p[i] - s[i];
    end
    t = d[0] * dv[0] + d[1] * dv[1] + d[2] * dv[2];
    sq = 0;
    if (t >= 0 && t <= len * 16384) begin
      c[0] = d[1] * dv[2] - d[2] * dv[1];
      c[1] = d[2] * dv[0] - d[0] * dv[2];
      c[2] = d[0] * dv[1] - d[1] * dv[0];
      for (int i = 0; i < 3; i++) sq += round_q22(c[i]) * round_q22(c[i]);
      r.region = REGION_PERP;
    end else if (t < 0) begin
      for (int i = 0; i < 3; i++) sq += d[i] * d[i];
      r.region = REGION_BEFORE;
    end else begin
      // end point rounded to Q8.8 at full width
      for (int i = 0; i < 3; i++) begin
        e = (dv[i] < 0) ? s[i] - round_q22(dv[i] * len) : s[i] + round_q22(dv[i] * len);
        q = p[i] - e;
        sq += q * q;
      end
      r.region = REGION_PAST;
    end
    if (sq > (64'd1 << ValW) - 1) sq = (64'd1 << ValW) - 1;
    if (seg_regs[CFG_ROOT][0]) begin
      root = 0;
      for (int b = RootBits; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= sq) root = trial;
      end
      r.value = root[ValW-1:0];
    end else begin
      r.value = sq[ValW-1:0];
    end
    return r;
  endfunction

  // write all eight registers back to back; block must be idle
  task automatic load_segment(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                              logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                              logic [15:0] len, logic root_mode);
    logic [15:0] vals [8];
    vals = '{sx, sy, sz, dx, dy, dz, len, {15'd0, root_mode}};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      seg_regs[i] = vals[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  // one point request; expectation queued at the accepting edge
  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            bit known, dist_t typed);
    if ($urandom_range(99) < sender_idle_pct) begin
      pt_in.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    pt_in.valid   <= 1'b1;
    pt_in.point_x <= x;
    pt_in.point_y <= y;
    pt_in.point_z <= z;
    @(posedge clk_i);
    while (!pt_in.ready) @(posedge clk_i);
    expected_dist.push_back(known ? typed : predict_distance(x, y, z));
  endtask

  task automatic wait_drained();
    pt_in.valid <= 1'b0;
    while (expected_dist.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // random segment: axis-aligned, a fixed unit-length diagonal, or any 16-bit direction
  task automatic random_segment(logic root_mode);
    logic [15:0] dv [3];
    logic [15:0] len;
    int pick;
    pick = $urandom_range(2);
    dv = '{16'd0, 16'd0, 16'd0};
    if (pick == 0) begin
      dv[$urandom_range(2)] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
    end else if (pick == 1) begin
      dv = '{16'sd9459, -16'sd9459, 16'sd9459};
    end else begin
      dv = '{16'($urandom), 16'($urandom), 16'($urandom)};
    end
    len = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4096));
    load_segment(16'($urandom), 16'($urandom), 16'($urandom), dv[0], dv[1], dv[2],
                 len, root_mode);
  endtask

  // random points: mostly near the segment start point, some anywhere
  task automatic random_points(int count);
    logic [15:0] x, y, z;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0) begin
        x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      end else begin
        x = seg_regs[CFG_START_X] + 16'($urandom_range(8192)) - 16'd2048;
        y = seg_regs[CFG_START_Y] + 16'($urandom_range(2048)) - 16'd1024;
        z = seg_regs[CFG_START_Z] + 16'($urandom_range(2048)) - 16'd1024;
      end
      send_point(x, y, z, 1'b0, '0);
    end
  endtask

  // result side: random stalls, compare with oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_out.valid && res_out.ready) begin
        if (expected_dist.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result value=%0d region=%0d",
                     res_out.distance_value, res_out.region);
        end else begin
          dist_t want;
          want = expected_dist.pop_front();
          if (res_out.distance_value !== want.value || res_out.region !== want.region) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value=%0d region=%0d, got value=%0d region=%0d",
                       want.value, want.region, res_out.distance_value, res_out.region);
          end
        end
      end
      res_out.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  initial begin
    #2ms;
    $display("point_segment_distance test failed");
    $finish;
  end

  initial begin
    point_row_t rows [$];
    seg_regs = '{16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd0};
    // reset state: start at origin, direction +x, zero length, squared mode
    rows = '{
      '{16'sd0, 16'sd0, 16'sd0, 1'b1, 38'd0, REGION_PERP},
      '{-16'sd256, 16'sd0, 16'sd0, 1'b1, 38'd65536, REGION_BEFORE},
      '{16'sd256, 16'sd0, 16'sd0, 1'b1, 38'd65536, REGION_PAST},
      '{16'sd0, 16'sd256, 16'sd0, 1'b1, 38'd65536, REGION_PERP},
      '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 38'd3221225472, REGION_BEFORE},
      '{16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 38'd3221028867, REGION_PAST},
      '{16'sd1, -16'sd32768, 16'sd32767, 1'b0, 38'd0, REGION_PERP},
      '{-16'sd1, 16'sd21845, -16'sd21846, 1'b0, 38'd0, REGION_PERP}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 35;
    receiver_idle_pct = 64;
    foreach (rows[i])
      send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].known,
                 '{rows[i].value, rows[i].region});
    wait_drained();

    // long segment along -z, root mode; checks interior, both ends, far corners
    load_segment(16'h8000, 16'h7fff, 16'h0000, 16'd0, 16'd0, -16'sd16384, 16'hffff, 1'b1);
    rows = '{
      '{-16'sd32768, 16'sd32767, 16'sd256, 1'b0, 38'd0, REGION_PERP},
      '{-16'sd32768, 16'sd32767, -16'sd32768, 1'b0, 38'd0, REGION_PERP},
      '{16'sd32767, -16'sd32768, 16'sd0, 1'b0, 38'd0, REGION_PERP},
      '{16'sd0, 16'sd0, 16'sd32767, 1'b0, 38'd0, REGION_BEFORE},
      '{16'sd0, 16'sd0, -16'sd32768, 1'b0, 38'd0, REGION_PERP}
    };
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, 1'b0, '0);
    wait_drained();

    // non-unit, out-of-range direction, full length, past-end rounding
    load_segment(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h2001,
                 16'hffff, 1'b0);
    for (int i = 0; i < 6; i++)
      send_point(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
    send_point(16'h8000, 16'h8000, 16'h8000, 1'b0, '0);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b0, '0);
    wait_drained();

    // random phases: heavy receiver idling, then heavy sender idling, then no idling
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        sender_idle_pct = 64;
        receiver_idle_pct = 35;
      end else if (ph == 4) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      random_segment(ph[0]);
      random_points(160);
      // hold off until the pipeline empties, then resume
      wait_drained();
      random_points(160);
      wait_drained();
    end

    if (mismatches == 0 && expected_dist.size() == 0)
      $display("point_segment_distance test passed");
    else
      $display("point_segment_distance test failed");
    $finish;
  end

endmodule
